### design/nts_pkg.sv
package nts_pkg;

  localparam int unsigned SCORE_DEPTH_DEFAULT = 256;
  localparam int unsigned TIMER_INPUT_HZ_DEFAULT = 1193180;

  localparam int unsigned NOTE_W = 7;
  localparam int unsigned MS_W = 16;
  localparam int unsigned DIV_W = 18;
  localparam int unsigned ROM_DEPTH = 128;

  localparam logic [DIV_W-1:0] DIV_MAX = '1;
  localparam logic [63:0] DIV_DENOM = 64'd440000000000;
  localparam int unsigned BASE_NOTE = 69;
  localparam int unsigned OCTAVE_OFFSET = 60;
  localparam int unsigned SEMITONES = 12;

  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_START  = 3'd2,
    KIND_STOP   = 3'd3,
    KIND_TICK   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [MS_W-1:0]   snd;
    logic [MS_W-1:0]   rst;
  } entry_t;

  typedef struct packed {
    logic cap_in;
    logic clr_count;
    logic append;
    logic set_accepted;
    logic start_play;
    logic finish;
    logic rem_dec;
    logic rd_play;
    logic rd_scan;
    logic scan_next;
    logic scan_inc;
    logic enter_sound;
    logic enter_rest;
    logic load_out;
  } nts_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  playing;
    logic  count_empty;
    logic  count_full;
    logic  rem_le1;
    logic  in_rest;
    logic  rd_snd_nz;
    logic  rd_rst_nz;
    logic  scan_done;
    logic  out_free;
  } nts_sts_t;

  typedef logic [DIV_W-1:0] div_rom_t [ROM_DEPTH];

  localparam logic [63:0] SEMITONE_POW [SEMITONES] = '{
    64'd1000000000, 64'd1059463094, 64'd1122462048, 64'd1189207115,
    64'd1259921050, 64'd1334839854, 64'd1414213562, 64'd1498307077,
    64'd1587401052, 64'd1681792831, 64'd1781797436, 64'd1887748625
  };

  // Octave q is counted downward from five octaves above the base note.
  function automatic logic [DIV_W-1:0] divisor_calc(input logic [63:0] hz,
                                                     input int unsigned n);
    int unsigned e;
    int unsigned q;
    logic [63:0] num;
    logic [63:0] v;
    e = BASE_NOTE + OCTAVE_OFFSET - n;
    q = 0;
    for (int i = 0; i < 11; i++) begin
      if (e >= SEMITONES) begin
        e = e - SEMITONES;
        q = q + 1;
      end
    end
    num = hz * SEMITONE_POW[e];
    if (q >= 5) begin
      num = num << (q - 5);
    end else begin
      num = num >> (5 - q);
    end
    v = num / DIV_DENOM;
    if (v > 64'(DIV_MAX)) begin
      return DIV_MAX;
    end
    return v[DIV_W-1:0];
  endfunction

  function automatic div_rom_t build_div_rom(input logic [63:0] hz);
    div_rom_t rom;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      rom[i] = divisor_calc(hz, i);
    end
    return rom;
  endfunction

endpackage

### design/note_score_tone_sequencer_unit.sv
// Channel  | Handshake            | Payload
// input    | in_valid / in_stall  | kind, note_number, sound_ms, rest_ms
// output   | out_valid / out_stall| tone_divisor, playing, load_accepted
//
// Clear, append, stop and a plain tick pass through the execute and response states.
// A tick that ends a phase adds a score read and check at the current note.
// Moving to a new note adds a read and a check per score entry examined, and a final
// end test when the score runs out, since the single score memory port is read once
// per entry and skipped notes are walked.
// Reset is synchronous and empties the score; no clearing pass is needed.
// A stalled output holds the result; the next input is taken meanwhile.
module note_score_tone_sequencer_unit #(
  parameter int unsigned SCORE_DEPTH = nts_pkg::SCORE_DEPTH_DEFAULT,
  parameter int unsigned TIMER_INPUT_HZ = nts_pkg::TIMER_INPUT_HZ_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 kind,
  input  logic [nts_pkg::NOTE_W-1:0] note_number,
  input  logic [nts_pkg::MS_W-1:0]   sound_ms,
  input  logic [nts_pkg::MS_W-1:0]   rest_ms,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [nts_pkg::DIV_W-1:0]  tone_divisor,
  output logic                       playing,
  output logic                       load_accepted
);
  import nts_pkg::*;

  nts_cmd_t cmd;
  nts_sts_t sts;

  nts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  nts_datapath #(
    .SCORE_DEPTH    (SCORE_DEPTH),
    .TIMER_INPUT_HZ (TIMER_INPUT_HZ)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .kind          (kind),
    .note_number   (note_number),
    .sound_ms      (sound_ms),
    .rest_ms       (rest_ms),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .tone_divisor  (tone_divisor),
    .playing       (playing),
    .load_accepted (load_accepted)
  );

endmodule

### design/nts_ctrl.sv
module nts_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  nts_pkg::nts_sts_t sts,
  output nts_pkg::nts_cmd_t cmd
);
  import nts_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_EXEC     = 7'b0000010,
    S_TICK_RD  = 7'b0000100,
    S_TICK_CHK = 7'b0001000,
    S_SCAN_RD  = 7'b0010000,
    S_SCAN_CHK = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESP;
        unique case (sts.kind)
          KIND_CLEAR: begin
            if (!sts.playing) begin
              cmd.clr_count = 1'b1;
              cmd.set_accepted = 1'b1;
            end
          end
          KIND_APPEND: begin
            if (!sts.playing && !sts.count_full) begin
              cmd.append = 1'b1;
              cmd.set_accepted = 1'b1;
            end
          end
          KIND_START: begin
            if (!sts.playing && !sts.count_empty) begin
              cmd.start_play = 1'b1;
              state_next = S_SCAN_RD;
            end
          end
          KIND_STOP: begin
            if (sts.playing) begin
              cmd.finish = 1'b1;
            end
          end
          KIND_TICK: begin
            if (sts.playing) begin
              cmd.rem_dec = 1'b1;
              if (sts.rem_le1) begin
                state_next = S_TICK_RD;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_TICK_RD: begin
        cmd.rd_play = 1'b1;
        state_next = S_TICK_CHK;
      end
      S_TICK_CHK: begin
        if (!sts.in_rest && sts.rd_rst_nz) begin
          cmd.enter_rest = 1'b1;
          state_next = S_RESP;
        end else begin
          cmd.scan_next = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_done) begin
          cmd.finish = 1'b1;
          state_next = S_RESP;
        end else begin
          cmd.rd_scan = 1'b1;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.rd_snd_nz) begin
          cmd.enter_sound = 1'b1;
          state_next = S_RESP;
        end else if (sts.rd_rst_nz) begin
          cmd.enter_rest = 1'b1;
          state_next = S_RESP;
        end else begin
          cmd.scan_inc = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/nts_datapath.sv
module nts_datapath #(
  parameter int unsigned SCORE_DEPTH = nts_pkg::SCORE_DEPTH_DEFAULT,
  parameter int unsigned TIMER_INPUT_HZ = nts_pkg::TIMER_INPUT_HZ_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [2:0]                  kind,
  input  logic [nts_pkg::NOTE_W-1:0]  note_number,
  input  logic [nts_pkg::MS_W-1:0]    sound_ms,
  input  logic [nts_pkg::MS_W-1:0]    rest_ms,
  input  nts_pkg::nts_cmd_t           cmd,
  output nts_pkg::nts_sts_t           sts,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [nts_pkg::DIV_W-1:0]   tone_divisor,
  output logic                        playing,
  output logic                        load_accepted
);
  import nts_pkg::*;

  localparam int unsigned CW = $clog2(SCORE_DEPTH + 1);
  localparam int unsigned AW = (SCORE_DEPTH > 1) ? $clog2(SCORE_DEPTH) : 1;
  localparam div_rom_t DIV_ROM = build_div_rom(64'(TIMER_INPUT_HZ));

  entry_t score_mem [SCORE_DEPTH];
  entry_t rd_entry;

  kind_t             cur_kind;
  logic [NOTE_W-1:0] cur_note;
  logic [MS_W-1:0]   cur_snd;
  logic [MS_W-1:0]   cur_rest;

  logic [CW-1:0]     score_count;
  logic [CW-1:0]     scan_idx;
  logic [AW-1:0]     play_index;
  logic              playing_flag;
  logic              in_rest_phase;
  logic [MS_W-1:0]   remaining_ms;
  logic [DIV_W-1:0]  current_divisor;
  logic              accepted;
  logic [AW-1:0]     rd_addr;

  assign rd_addr = cmd.rd_scan ? scan_idx[AW-1:0] : play_index;

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      score_mem[score_count[AW-1:0]] <= '{note: cur_note, snd: cur_snd, rst: cur_rest};
    end
    if (cmd.rd_play || cmd.rd_scan) begin
      rd_entry <= score_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      cur_kind <= kind_t'(kind);
      cur_note <= note_number;
      cur_snd  <= sound_ms;
      cur_rest <= rest_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_count     <= '0;
      scan_idx        <= '0;
      play_index      <= '0;
      playing_flag    <= 1'b0;
      in_rest_phase   <= 1'b0;
      remaining_ms    <= '0;
      current_divisor <= '0;
      accepted        <= 1'b0;
    end else begin
      if (cmd.cap_in) begin
        accepted <= 1'b0;
      end
      if (cmd.set_accepted) begin
        accepted <= 1'b1;
      end
      if (cmd.clr_count) begin
        score_count <= '0;
      end
      if (cmd.append) begin
        score_count <= score_count + CW'(1);
      end
      if (cmd.start_play) begin
        playing_flag <= 1'b1;
        scan_idx <= '0;
      end
      if (cmd.rem_dec && remaining_ms != '0) begin
        remaining_ms <= remaining_ms - MS_W'(1);
      end
      if (cmd.scan_next) begin
        scan_idx <= CW'(play_index) + CW'(1);
      end
      if (cmd.scan_inc) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (cmd.rd_scan) begin
        play_index <= scan_idx[AW-1:0];
      end
      if (cmd.enter_sound) begin
        in_rest_phase <= 1'b0;
        remaining_ms <= rd_entry.snd;
        current_divisor <= DIV_ROM[rd_entry.note];
      end
      if (cmd.enter_rest) begin
        in_rest_phase <= 1'b1;
        remaining_ms <= rd_entry.rst;
        current_divisor <= '0;
      end
      if (cmd.finish) begin
        playing_flag    <= 1'b0;
        current_divisor <= '0;
        score_count     <= '0;
        play_index      <= '0;
        in_rest_phase   <= 1'b0;
        remaining_ms    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      tone_divisor  <= current_divisor;
      playing       <= playing_flag;
      load_accepted <= accepted;
    end
  end

  always_comb begin
    sts.kind        = cur_kind;
    sts.playing     = playing_flag;
    sts.count_empty = (score_count == '0);
    sts.count_full  = (score_count == CW'(SCORE_DEPTH));
    sts.rem_le1     = (remaining_ms <= MS_W'(1));
    sts.in_rest     = in_rest_phase;
    sts.rd_snd_nz   = (rd_entry.snd != '0);
    sts.rd_rst_nz   = (rd_entry.rst != '0);
    sts.scan_done   = (scan_idx >= score_count);
    sts.out_free    = !out_valid || !out_stall;
  end

endmodule

### design/nts_checker.sv
module nts_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [nts_pkg::DIV_W-1:0]  tone_divisor,
  input logic                       playing,
  input logic                       load_accepted
);
  import nts_pkg::*;

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tone_divisor) &&
      $stable(playing) && $stable(load_accepted))
    else $error("stalled result changed");

  // A load is only taken while the score is not playing.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && load_accepted |-> !playing)
    else $error("load accepted while playing");

  // The tone is silent whenever play is off.
  a_silent_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !playing |-> tone_divisor == '0)
    else $error("tone sounding while not playing");

  // The unit works on one item at a time after a transfer.
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

endmodule

bind note_score_tone_sequencer_unit nts_checker u_nts_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .tone_divisor  (tone_divisor),
  .playing       (playing),
  .load_accepted (load_accepted)
);
